// ----- rtl/flash_erase_range_planner_macros.svh -----
// Assertion macros for the flash erase range planner checker.
// No dependencies; included by the checker file only.
`ifndef FLASH_ERASE_RANGE_PLANNER_MACROS_SVH
`define FLASH_ERASE_RANGE_PLANNER_MACROS_SVH

// Same-cycle implication, disabled during reset.
`define FERP_ASSERT_SAME(lbl, clk, rst, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("flash erase planner check failed");

// Next-cycle implication, disabled during reset.
`define FERP_ASSERT_NEXT(lbl, clk, rst, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("flash erase planner check failed");

`endif

// ----- rtl/ferp_pkg.sv -----
// Shared types and constants of the flash erase range planner.
// No dependencies; used by every module of the block.
package ferp_pkg;

  localparam int NUM_CMD     = 6;
  localparam int ADDR_W      = 32;
  localparam int WIN_W       = 25;
  localparam int COUNT_W     = 17;
  localparam int CFG_INDEX_W = 4;
  localparam int IN_TDATA_W  = 64;
  localparam int OUT_TDATA_W = 56;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_ADDR  = 2'd1,
    ST_RANGE = 2'd2,
    ST_ALIGN = 2'd3
  } status_t;

  typedef enum logic [1:0] {
    SZ_256 = 2'd0,
    SZ_1K  = 2'd1,
    SZ_32K = 2'd2
  } size_t;

  localparam logic [CFG_INDEX_W-1:0] REG_WIN_BASE     = 4'd0;
  localparam logic [CFG_INDEX_W-1:0] REG_WINDOW_BYTES = 4'd1;

  localparam logic [ADDR_W-1:0] BASE_RESET   = 32'h0800_0000;
  localparam logic [WIN_W-1:0]  WINDOW_RESET = 25'h000_F800;

  // Command slots in emission order
  localparam logic [2:0] SLOT_F32  = 3'd0;
  localparam logic [2:0] SLOT_B32  = 3'd1;
  localparam logic [2:0] SLOT_F1K  = 3'd2;
  localparam logic [2:0] SLOT_B1K  = 3'd3;
  localparam logic [2:0] SLOT_F256 = 3'd4;
  localparam logic [2:0] SLOT_B256 = 3'd5;

  typedef struct packed {
    status_t                             status;
    logic [NUM_CMD-1:0]                  mask;
    logic [NUM_CMD-1:0][ADDR_W-1:0]      addr;
    logic [NUM_CMD-1:0][COUNT_W-1:0]     count;
  } plan_t;

  function automatic size_t slot_size(input logic [2:0] slot);
    size_t sz;
    case (slot)
      SLOT_F32, SLOT_B32:   sz = SZ_32K;
      SLOT_F1K, SLOT_B1K:   sz = SZ_1K;
      SLOT_F256, SLOT_B256: sz = SZ_256;
      default:              sz = SZ_256;
    endcase
    return sz;
  endfunction

endpackage

// ----- rtl/ferp_plan.sv -----
// Four-stage planning pipeline: window checks, then 32 KB, 1 KB and 256 B split.
// Depends on ferp_pkg; produces one plan_t per request for ferp_emit.
module ferp_plan #(
  parameter int ADDR_WIDTH = 32
) (
  input  logic                      clk,
  input  logic                      rst,
  input  logic [31:0]               win_base,
  input  logic [24:0]               window_bytes,
  input  logic                      in_valid,
  output logic                      in_ready,
  input  logic [31:0]               start_address,
  input  logic [31:0]               length_bytes,
  output logic                      out_valid,
  input  logic                      out_ready,
  output ferp_pkg::plan_t           out_plan
);

  localparam logic [32:0] LIMIT = 33'(1) << ADDR_WIDTH;

  logic adv1, adv2, adv3, adv4;

  // stage 1: sums
  logic        s1_valid;
  logic [31:0] s1_start, s1_len;
  logic [32:0] s1_win_end, s1_end;
  logic [32:0] win_raw, win_end_c;

  // stage 2: status and head/tail split
  logic                s2_valid;
  ferp_pkg::status_t   s2_status;
  logic [31:0]         s2_start, s2_end, s2_a1, s2_l1;
  logic [15:0]         s2_l0;
  ferp_pkg::status_t   status_c;
  logic                big_c, mid_c;
  logic [15:0]         l0_c;

  // stage 3: 32 KB commands
  logic                s3_valid;
  ferp_pkg::status_t   s3_status;
  logic [31:0]         s3_start, s3_end, s3_a1, s3_b32_addr;
  logic [14:0]         s3_l0, s3_l1;
  logic                s3_f32, s3_b32;
  logic [16:0]         s3_b32_cnt;
  logic                f32_c, b32_c;
  logic [14:0]         l0p_c, l1p_c;
  logic [31:0]         a1p_c, b32_diff;

  // stage 4: 1 KB and 256 B commands
  logic                s4_valid;
  ferp_pkg::plan_t     s4_plan;
  logic                f1_c, b1_c;
  logic [9:0]          l0pp_c, l1pp_c;
  logic [31:0]         a1pp_c;
  logic [14:0]         f1_diff, b1_diff;
  ferp_pkg::plan_t     plan_c;

  assign adv4     = !s4_valid || out_ready;
  assign adv3     = !s3_valid || adv4;
  assign adv2     = !s2_valid || adv3;
  assign adv1     = !s1_valid || adv2;
  assign in_ready = adv1;

  assign out_valid = s4_valid;
  assign out_plan  = s4_plan;

  // Window end clipped to the address space
  assign win_raw   = {1'b0, win_base} + {8'b0, window_bytes};
  assign win_end_c = (win_raw > LIMIT) ? LIMIT : win_raw;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (adv1) begin
      s1_valid <= in_valid;
    end
    if (adv1) begin
      s1_start   <= start_address;
      s1_len     <= length_bytes;
      s1_win_end <= win_end_c;
      s1_end     <= {1'b0, start_address} + {1'b0, length_bytes};
    end
  end

  always_comb begin
    if ((s1_start < win_base) || ({1'b0, s1_start} >= s1_win_end)) begin
      status_c = ferp_pkg::ST_ADDR;
    end else if (s1_end > s1_win_end) begin
      status_c = ferp_pkg::ST_RANGE;
    end else if ((s1_start[7:0] != 8'd0) || (s1_len[7:0] != 8'd0) || (s1_len == 32'd0)) begin
      status_c = ferp_pkg::ST_ALIGN;
    end else begin
      status_c = ferp_pkg::ST_OK;
    end
    big_c = (s1_len[31:15] != 17'd0);
    mid_c = (s1_len[31:10] != 22'd0);
    // Head runs up to the next boundary of the largest granule that fits
    if (big_c) begin
      l0_c = 16'h8000 - {1'b0, s1_start[14:0]};
    end else if (mid_c) begin
      l0_c = 16'h0400 - {6'b0, s1_start[9:0]};
    end else begin
      l0_c = s1_len[15:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s2_valid <= 1'b0;
    end else if (adv2) begin
      s2_valid <= s1_valid;
    end
    if (adv2) begin
      s2_status <= status_c;
      s2_start  <= s1_start;
      s2_end    <= s1_end[31:0];
      s2_l0     <= l0_c;
      s2_a1     <= s1_start + {16'b0, l0_c};
      s2_l1     <= s1_len - {16'b0, l0_c};
    end
  end

  always_comb begin
    f32_c = s2_l0[15];
    l0p_c = f32_c ? 15'd0 : s2_l0[14:0];
    b32_c = (s2_l1[31:15] != 17'd0);
    if (b32_c) begin
      a1p_c = {s2_end[31:15], 15'd0};
      l1p_c = s2_end[14:0];
    end else begin
      a1p_c = s2_a1;
      l1p_c = s2_l1[14:0];
    end
    b32_diff = s2_l1 - {17'b0, l1p_c};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s3_valid <= 1'b0;
    end else if (adv3) begin
      s3_valid <= s2_valid;
    end
    if (adv3) begin
      s3_status   <= s2_status;
      s3_start    <= s2_start;
      s3_end      <= s2_end;
      s3_a1       <= a1p_c;
      s3_l0       <= l0p_c;
      s3_l1       <= l1p_c;
      s3_f32      <= f32_c;
      s3_b32      <= b32_c;
      s3_b32_addr <= s2_a1;
      s3_b32_cnt  <= b32_diff[31:15];
    end
  end

  always_comb begin
    f1_c   = (s3_l0[14:10] != 5'd0);
    // Remaining head below the next 1 KB boundary
    l0pp_c = f1_c ? (10'd0 - s3_start[9:0]) : s3_l0[9:0];
    f1_diff = s3_l0 - {5'b0, l0pp_c};
    b1_c   = (s3_l1[14:10] != 5'd0);
    if (b1_c) begin
      a1pp_c = {s3_end[31:10], 10'd0};
      l1pp_c = s3_end[9:0];
    end else begin
      a1pp_c = s3_a1;
      l1pp_c = s3_l1[9:0];
    end
    b1_diff = s3_l1 - {5'b0, l1pp_c};

    plan_c        = '0;
    plan_c.status = s3_status;
    if (s3_status != ferp_pkg::ST_OK) begin
      plan_c.mask[ferp_pkg::SLOT_F32] = 1'b1;
    end else begin
      plan_c.mask[ferp_pkg::SLOT_F32]   = s3_f32;
      plan_c.addr[ferp_pkg::SLOT_F32]   = s3_start;
      plan_c.count[ferp_pkg::SLOT_F32]  = 17'd1;
      plan_c.mask[ferp_pkg::SLOT_B32]   = s3_b32;
      plan_c.addr[ferp_pkg::SLOT_B32]   = s3_b32_addr;
      plan_c.count[ferp_pkg::SLOT_B32]  = s3_b32_cnt;
      plan_c.mask[ferp_pkg::SLOT_F1K]   = f1_c;
      plan_c.addr[ferp_pkg::SLOT_F1K]   = s3_start + {22'b0, l0pp_c};
      plan_c.count[ferp_pkg::SLOT_F1K]  = {12'b0, f1_diff[14:10]};
      plan_c.mask[ferp_pkg::SLOT_B1K]   = b1_c;
      plan_c.addr[ferp_pkg::SLOT_B1K]   = s3_a1;
      plan_c.count[ferp_pkg::SLOT_B1K]  = {12'b0, b1_diff[14:10]};
      plan_c.mask[ferp_pkg::SLOT_F256]  = (l0pp_c != 10'd0);
      plan_c.addr[ferp_pkg::SLOT_F256]  = s3_start;
      plan_c.count[ferp_pkg::SLOT_F256] = {15'b0, l0pp_c[9:8]};
      plan_c.mask[ferp_pkg::SLOT_B256]  = (l1pp_c != 10'd0);
      plan_c.addr[ferp_pkg::SLOT_B256]  = a1pp_c;
      plan_c.count[ferp_pkg::SLOT_B256] = {15'b0, l1pp_c[9:8]};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s4_valid <= 1'b0;
    end else if (adv4) begin
      s4_valid <= s3_valid;
    end
    if (adv4) begin
      s4_plan <= plan_c;
    end
  end

endmodule

// ----- rtl/ferp_emit.sv -----
// Output serialiser: holds one plan and sends its commands one per transaction.
// Depends on ferp_pkg; fed by ferp_plan.
module ferp_emit (
  input  logic                                  clk,
  input  logic                                  rst,
  input  logic                                  in_valid,
  output logic                                  in_ready,
  input  ferp_pkg::plan_t                       in_plan,
  output logic                                  m_tvalid,
  input  logic                                  m_tready,
  output logic [ferp_pkg::OUT_TDATA_W-1:0]      m_tdata,
  output logic                                  m_tlast
);

  logic [ferp_pkg::NUM_CMD-1:0]                         mask;
  ferp_pkg::status_t                                    status;
  logic [ferp_pkg::NUM_CMD-1:0][ferp_pkg::ADDR_W-1:0]   addr;
  logic [ferp_pkg::NUM_CMD-1:0][ferp_pkg::COUNT_W-1:0]  count;

  logic [ferp_pkg::NUM_CMD-1:0]   sel, rest;
  logic                           take, load;
  ferp_pkg::size_t                blk_size;
  logic [ferp_pkg::ADDR_W-1:0]    blk_addr;
  logic [ferp_pkg::COUNT_W-1:0]   blk_count;

  assign sel      = mask & (~mask + 6'd1);
  assign rest     = mask & (mask - 6'd1);
  assign m_tvalid = (mask != '0);
  assign m_tlast  = (rest == '0);
  assign take     = m_tvalid && m_tready;
  // Refill as the last command of the current plan leaves
  assign load     = !m_tvalid || (take && m_tlast);
  assign in_ready = load;

  always_comb begin
    blk_size  = ferp_pkg::SZ_256;
    blk_addr  = '0;
    blk_count = '0;
    for (int i = 0; i < ferp_pkg::NUM_CMD; i++) begin
      if (sel[i]) begin
        blk_size  = ferp_pkg::slot_size(3'(i));
        blk_addr  = addr[i];
        blk_count = count[i];
      end
    end
    if (status != ferp_pkg::ST_OK) begin
      blk_size = ferp_pkg::SZ_256;
    end
  end

  assign m_tdata = {3'b000, blk_count, blk_addr, blk_size, status};

  always_ff @(posedge clk) begin
    if (rst) begin
      mask <= '0;
    end else if (load) begin
      mask <= in_valid ? in_plan.mask : '0;
    end else if (take) begin
      mask <= rest;
    end
    if (load && in_valid) begin
      status <= in_plan.status;
      addr   <= in_plan.addr;
      count  <= in_plan.count;
    end
  end

endmodule

// ----- rtl/flash_erase_range_planner.sv -----
// Flash erase range planner: four-stage planning pipeline and output serialiser.
// Depends on ferp_pkg, ferp_plan and ferp_emit.
//
// Usage:
//   Requests enter on the s_ channel (start address, byte length). Each request
//   yields one to six erase commands on the m_ channel, in the order front 32 KB,
//   back 32 KB, front 1 KB, back 1 KB, front 256 B, back 256 B; tlast marks the
//   final command. A failed check yields one transaction carrying the status code.
//   The window base and window_bytes are written on the cfg_ channel, which is
//   always ready; write them only while no request is in flight.
//   The first command of a request reaches the m_ channel after passing the four
//   planning stages and the serialiser's plan register. Throughput: one command
//   per cycle on the output while m_tready is high; the four planning stages
//   accept a request every cycle while they have room, and the next plan enters
//   the serialiser in the cycle its predecessor's last command leaves.
//   When m_tready is low, the serialiser holds its command and the planning
//   stages fill up and then hold, so s_tready drops; nothing is lost or repeated.
//   Reset empties every stage and restores the register defaults (base
//   0x0800_0000, window 0xF800 bytes).
module flash_erase_range_planner #(
  parameter int ADDR_WIDTH = 32
) (
  input  logic                                  clk,
  input  logic                                  rst,
  input  logic                                  s_tvalid,
  output logic                                  s_tready,
  // start_address [31:0], length_bytes [63:32]
  input  logic [ferp_pkg::IN_TDATA_W-1:0]       s_tdata,
  output logic                                  m_tvalid,
  input  logic                                  m_tready,
  // status [1:0], block_size [3:2], block_address [35:4], block_count [52:36], zero [55:53]
  output logic [ferp_pkg::OUT_TDATA_W-1:0]      m_tdata,
  output logic                                  m_tlast,
  input  logic                                  cfg_valid,
  output logic                                  cfg_ready,
  input  logic [ferp_pkg::CFG_INDEX_W-1:0]      cfg_index,
  input  logic [31:0]                           cfg_data
);

  logic [ferp_pkg::ADDR_W-1:0] win_base;
  logic [ferp_pkg::WIN_W-1:0]  window_bytes;

  logic            plan_valid, plan_ready;
  ferp_pkg::plan_t plan;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      win_base     <= ferp_pkg::BASE_RESET;
      window_bytes <= ferp_pkg::WINDOW_RESET;
    end else if (cfg_valid) begin
      case (cfg_index)
        ferp_pkg::REG_WIN_BASE:     win_base     <= cfg_data;
        ferp_pkg::REG_WINDOW_BYTES: window_bytes <= cfg_data[ferp_pkg::WIN_W-1:0];
        default: ;
      endcase
    end
  end

  ferp_plan #(
    .ADDR_WIDTH (ADDR_WIDTH)
  ) u_plan (
    .clk           (clk),
    .rst           (rst),
    .win_base      (win_base),
    .window_bytes  (window_bytes),
    .in_valid      (s_tvalid),
    .in_ready      (s_tready),
    .start_address (s_tdata[31:0]),
    .length_bytes  (s_tdata[63:32]),
    .out_valid     (plan_valid),
    .out_ready     (plan_ready),
    .out_plan      (plan)
  );

  ferp_emit u_emit (
    .clk      (clk),
    .rst      (rst),
    .in_valid (plan_valid),
    .in_ready (plan_ready),
    .in_plan  (plan),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tlast  (m_tlast)
  );

endmodule

// ----- rtl/ferp_checker.sv -----
// Port-level checks of the flash erase range planner output, bound to the top.
// Depends on ferp_pkg and flash_erase_range_planner_macros.svh.
`include "flash_erase_range_planner_macros.svh"

module ferp_checker (
  input logic                              clk,
  input logic                              rst,
  input logic                              m_tvalid,
  input logic                              m_tready,
  input logic [ferp_pkg::OUT_TDATA_W-1:0]  m_tdata,
  input logic                              m_tlast
);

  // A rejected request gives a single, empty, final transaction
  `FERP_ASSERT_SAME(a_err_alone, clk, rst, m_tvalid && (m_tdata[1:0] != ferp_pkg::ST_OK), m_tlast && (m_tdata[52:2] == '0))
  // Every erase command covers at least one block
  `FERP_ASSERT_SAME(a_cmd_nonzero, clk, rst, m_tvalid && (m_tdata[1:0] == ferp_pkg::ST_OK), m_tdata[52:36] != '0)
  // The rest of a request follows without a gap
  `FERP_ASSERT_NEXT(a_cmd_follows, clk, rst, m_tvalid && m_tready && !m_tlast, m_tvalid)
  // A stalled command holds
  `FERP_ASSERT_NEXT(a_hold, clk, rst, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata) && $stable(m_tlast))

endmodule

bind flash_erase_range_planner ferp_checker u_check (
  .clk      (clk),
  .rst      (rst),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready),
  .m_tdata  (m_tdata),
  .m_tlast  (m_tlast)
);

// ----- sim/tb_flash_erase_range_planner.sv -----
// Self-checking testbench for the flash erase range planner.
// Depends on ferp_pkg and the flash_erase_range_planner RTL; predicts every
// erase command per request and checks the output stream against it.
module tb_flash_erase_range_planner;

  localparam logic [63:0] GRAIN_256 = 64'h100;
  localparam logic [63:0] GRAIN_1K  = 64'h400;
  localparam logic [63:0] GRAIN_32K = 64'h8000;
  localparam int          SETTLE_CYCLES = 12;
  localparam int          DRAIN_LIMIT   = 20000;

  typedef struct {
    ferp_pkg::status_t status;
    ferp_pkg::size_t   grain;
    logic [31:0]       addr;
    logic [16:0]       count;
    logic              last;
  } erase_cmd_t;

  class erase_plan_board;
    logic [31:0] win_base;
    logic [24:0] window_bytes;
    erase_cmd_t  pending_cmds[$];
    erase_cmd_t  plan_cmds[$];
    int          errors;

    function new();
      win_base     = ferp_pkg::BASE_RESET;
      window_bytes = ferp_pkg::WINDOW_RESET;
      errors       = 0;
    endfunction

    function void write_reg(logic [3:0] idx, logic [31:0] data);
      case (idx)
        ferp_pkg::REG_WIN_BASE:     win_base = data;
        ferp_pkg::REG_WINDOW_BYTES: window_bytes = data[24:0];
        default: ;
      endcase
    endfunction

    // Window end without wrap, clipped to the address space
    function logic [63:0] window_end();
      logic [63:0] wend;
      wend = {32'd0, win_base} + {39'd0, window_bytes};
      if (wend > (64'd1 << ferp_pkg::ADDR_W)) wend = 64'd1 << ferp_pkg::ADDR_W;
      return wend;
    endfunction

    function int pending();
      return pending_cmds.size();
    endfunction

    function void add_cmd(ferp_pkg::status_t st, ferp_pkg::size_t gr, logic [63:0] adr,
                          logic [63:0] cnt);
      erase_cmd_t c;
      c.status = st;
      c.grain  = gr;
      c.addr   = adr[31:0];
      c.count  = cnt[16:0];
      c.last   = 1'b0;
      plan_cmds.push_back(c);
    endfunction

    // Split one accepted request into its erase commands
    function void note_request(logic [31:0] start_a, logic [31:0] len_b);
      logic [63:0] st, ln, wend, a0, a1, l0, l1, whole, fin, from;
      ferp_pkg::status_t code;
      erase_cmd_t c;
      st   = {32'd0, start_a};
      ln   = {32'd0, len_b};
      wend = window_end();
      a1   = 0;
      l1   = 0;
      plan_cmds.delete();
      code = ferp_pkg::ST_OK;
      if (st < {32'd0, win_base} || st >= wend) code = ferp_pkg::ST_ADDR;
      else if (st + ln > wend) code = ferp_pkg::ST_RANGE;
      else if (st[7:0] != 0 || ln[7:0] != 0 || ln == 0) code = ferp_pkg::ST_ALIGN;

      if (code != ferp_pkg::ST_OK) begin
        add_cmd(code, ferp_pkg::SZ_256, 0, 0);
      end else begin
        a0 = st;
        if (ln >= GRAIN_32K) begin
          l0 = GRAIN_32K - (a0 & (GRAIN_32K - 1));
          a1 = a0 + l0;
          l1 = ln - l0;
        end else if (ln >= GRAIN_1K) begin
          l0 = GRAIN_1K - (a0 & (GRAIN_1K - 1));
          a1 = a0 + l0;
          l1 = ln - l0;
        end else begin
          l0 = ln;
        end
        if (l0 >= GRAIN_32K) begin
          whole = l0;
          l0 = (a0 & (GRAIN_32K - 1)) != 0 ? GRAIN_32K - (a0 & (GRAIN_32K - 1)) : 0;
          add_cmd(ferp_pkg::ST_OK, ferp_pkg::SZ_32K, a0 + l0, (whole - l0) >> 15);
        end
        if (l1 >= GRAIN_32K) begin
          from  = a1;
          whole = l1;
          fin   = a1 + l1;
          if ((fin & (GRAIN_32K - 1)) != 0) begin
            a1 = fin & ~(GRAIN_32K - 1);
            l1 = fin & (GRAIN_32K - 1);
          end else begin
            l1 = 0;
          end
          add_cmd(ferp_pkg::ST_OK, ferp_pkg::SZ_32K, from, (whole - l1) >> 15);
        end
        if (l0 >= GRAIN_1K) begin
          whole = l0;
          l0 = (a0 & (GRAIN_1K - 1)) != 0 ? GRAIN_1K - (a0 & (GRAIN_1K - 1)) : 0;
          add_cmd(ferp_pkg::ST_OK, ferp_pkg::SZ_1K, a0 + l0, (whole - l0) >> 10);
        end
        if (l1 >= GRAIN_1K) begin
          from  = a1;
          whole = l1;
          fin   = a1 + l1;
          if ((fin & (GRAIN_1K - 1)) != 0) begin
            a1 = fin & ~(GRAIN_1K - 1);
            l1 = fin & (GRAIN_1K - 1);
          end else begin
            l1 = 0;
          end
          add_cmd(ferp_pkg::ST_OK, ferp_pkg::SZ_1K, from, (whole - l1) >> 10);
        end
        if (l0 != 0) add_cmd(ferp_pkg::ST_OK, ferp_pkg::SZ_256, a0, l0 >> 8);
        if (l1 != 0) add_cmd(ferp_pkg::ST_OK, ferp_pkg::SZ_256, a1, l1 >> 8);
      end

      foreach (plan_cmds[i]) begin
        c = plan_cmds[i];
        c.last = (i == plan_cmds.size() - 1);
        pending_cmds.push_back(c);
      end
    endfunction

    function void field_ok(string name, logic [31:0] want, logic [31:0] got);
      if (want !== got) begin
        $error("%s: expected %0h, actual %0h", name, want, got);
        errors++;
      end
    endfunction

    function void check_command(logic [ferp_pkg::OUT_TDATA_W-1:0] tdata, logic tlast);
      erase_cmd_t c;
      if (pending_cmds.size() == 0) begin
        $error("erase command with no request behind it: tdata %0h tlast %0b", tdata, tlast);
        errors++;
        return;
      end
      c = pending_cmds.pop_front();
      field_ok("status", 32'(c.status), 32'(tdata[1:0]));
      field_ok("block_size", 32'(c.grain), 32'(tdata[3:2]));
      field_ok("block_address", c.addr, tdata[35:4]);
      field_ok("block_count", 32'(c.count), 32'(tdata[52:36]));
      field_ok("pad", 32'd0, 32'(tdata[55:53]));
      field_ok("last", 32'(c.last), 32'(tlast));
    endfunction

    function void close();
      if (pending_cmds.size() != 0) begin
        $error("%0d erase commands never arrived", pending_cmds.size());
        errors++;
      end
    endfunction
  endclass

  logic                                clk;
  logic                                rst;
  logic                                s_tvalid;
  logic                                s_tready;
  logic [ferp_pkg::IN_TDATA_W-1:0]     s_tdata;
  logic                                m_tvalid;
  logic                                m_tready;
  logic [ferp_pkg::OUT_TDATA_W-1:0]    m_tdata;
  logic                                m_tlast;
  logic                                cfg_valid;
  logic                                cfg_ready;
  logic [ferp_pkg::CFG_INDEX_W-1:0]    cfg_index;
  logic [31:0]                         cfg_data;

  erase_plan_board board = new();
  bit              quiet = 1'b0;

  flash_erase_range_planner #(.ADDR_WIDTH(32)) DUT (
    .clk       (clk),
    .rst       (rst),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .m_tlast   (m_tlast),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    #4000000;
    $display("Mismatches found");
    $finish;
  end

  function automatic int idle_draw();
    return quiet ? 0 : $urandom_range(0, 17);
  endfunction

  // Check every command transaction at the rising edge
  always @(posedge clk) begin
    if (!rst && m_tvalid && m_tready) board.check_command(m_tdata, m_tlast);
  end

  // Result side: hold tready low for a random stretch, then take one transaction
  initial begin
    int gap;
    m_tready = 1'b0;
    wait (rst == 1'b0);
    @(negedge clk);
    forever begin
      gap = idle_draw();
      if (gap > 0) begin
        m_tready <= 1'b0;
        repeat (gap) @(negedge clk);
      end
      m_tready <= 1'b1;
      do @(posedge clk); while (!m_tvalid);
      @(negedge clk);
    end
  end

  task automatic send_request(input logic [31:0] start_a, input logic [31:0] len_b);
    int gap;
    if ($urandom_range(0, 39) == 0) quiet = !quiet;
    gap = idle_draw();
    if (gap > 0) begin
      s_tvalid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    s_tdata  <= {len_b, start_a};
    s_tvalid <= 1'b1;
    do @(posedge clk); while (!s_tready);
    board.note_request(start_a, len_b);
    @(negedge clk);
  endtask

  // Hold off requests until every command is out, then let the pipeline settle
  task automatic drain();
    int waited;
    waited = 0;
    s_tvalid <= 1'b0;
    while (board.pending() != 0 && waited < DRAIN_LIMIT) begin
      @(negedge clk);
      waited++;
    end
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  task automatic cfg_write(input logic [3:0] idx, input logic [31:0] data);
    @(negedge clk);
    cfg_index <= idx;
    cfg_data  <= data;
    cfg_valid <= 1'b1;
    do @(posedge clk); while (!cfg_ready);
    board.write_reg(idx, data);
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  task automatic set_window(input logic [31:0] base, input logic [24:0] win);
    drain();
    cfg_write(ferp_pkg::REG_WIN_BASE, base);
    cfg_write(ferp_pkg::REG_WINDOW_BYTES, {7'd0, win});
  endtask

  // Edges of the default window: full span, last block, each error and its priority
  task automatic directed_requests();
    logic [31:0] b, w;
    b = board.win_base;
    w = 32'(board.window_end());
    send_request(b, 32'h100);
    send_request(b, 32'hF800);
    send_request(b + 32'h100, 32'hF700);
    send_request(b + 32'h7300, 32'h8500);
    send_request(w - 32'h100, 32'h100);
    send_request(b - 32'd1, 32'h100);
    send_request(w, 32'h100);
    send_request(32'h0, 32'h0);
    send_request(32'hFFFF_FFFF, 32'hFFFF_FFFF);
    send_request(b, 32'hF900);
    send_request(b + 32'h100, 32'hFFFF_FFFF);
    send_request(w - 32'h100, 32'hFFFF_FF00);
    send_request(b, 32'h0);
    send_request(b + 32'h80, 32'h100);
    send_request(b, 32'h180);
    send_request(b + 32'h1, 32'h1);
    send_request(b + 32'h400, 32'h400);
    send_request(b + 32'h8000, 32'h7800);
    send_request(b, 32'h8000);
    send_request(b + 32'h300, 32'h8100);
  endtask

  task automatic random_requests(input int n);
    logic [63:0] lo, wend, st, ln, room, nblk;
    int kind;
    for (int i = 0; i < n; i++) begin
      wend = board.window_end();
      lo   = ({32'd0, board.win_base} + 64'hFF) & ~64'hFF;
      kind = $urandom_range(0, 99);
      // no aligned block fits: only noise makes sense
      if (lo + GRAIN_256 > wend) kind = 99;
      if (kind < 92) begin
        st = lo + (64'($urandom_range(0, 32'((wend - lo) >> 8) - 1)) << 8);
        case ($urandom_range(0, 2))
          0: if ((st & ~(GRAIN_32K - 1)) >= lo) st &= ~(GRAIN_32K - 1);
          1: if ((st & ~(GRAIN_1K - 1)) >= lo) st &= ~(GRAIN_1K - 1);
          default: ;
        endcase
        room = (wend - st) >> 8;
        case ($urandom_range(0, 9))
          0, 1, 2, 3: nblk = 64'($urandom_range(1, 4));
          4, 5, 6:    nblk = 64'($urandom_range(1, 160));
          7:          nblk = room;
          default:    nblk = 64'($urandom_range(1, 32'(room)));
        endcase
        if (nblk > room) nblk = room;
        ln = nblk << 8;
        if (kind >= 76 && kind < 84) begin
          // misaligned start or length, or nothing to erase
          case ($urandom_range(0, 2))
            0:       st[7:0] = 8'($urandom_range(1, 255));
            1:       ln[7:0] = 8'($urandom_range(1, 255));
            default: ln = 0;
          endcase
        end else if (kind >= 84) begin
          // run past the window end
          if ($urandom_range(0, 1) == 0) ln = (room + $urandom_range(1, 300)) << 8;
          else ln = {32'd0, $urandom} | (room << 8);
        end
      end else begin
        st = {32'd0, $urandom};
        ln = {32'd0, $urandom};
        if ($urandom_range(0, 3) == 0) st = {32'd0, board.win_base} - $urandom_range(1, 1024);
      end
      send_request(st[31:0], ln[31:0]);
      if ($urandom_range(0, 59) == 0) drain();
    end
  endtask

  initial begin
    rst       = 1'b1;
    s_tvalid  = 1'b0;
    s_tdata   = '0;
    cfg_valid = 1'b0;
    cfg_index = '0;
    cfg_data  = '0;
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    directed_requests();
    random_requests(55);

    set_window(32'h0, 25'd256);
    random_requests(40);

    set_window(32'h0, 25'h100_0000);
    random_requests(60);

    // window reaching past the top of the address space
    set_window(32'hFFFF_0000, 25'h100_0000);
    send_request(32'hFFFF_FF00, 32'h100);
    send_request(32'hFFFF_0000, 32'h1_0000);
    send_request(32'hFFFF_0000, 32'h1_0100);
    random_requests(60);

    set_window(32'h2000_0300, 25'h1_2345);
    cfg_write(4'(ferp_pkg::REG_WINDOW_BYTES + $urandom_range(1, 14)), $urandom);
    random_requests(60);

    set_window(32'hFFFF_FFFF, 25'd256);
    random_requests(30);

    repeat (2) begin
      set_window($urandom, 25'($urandom_range(256, 32'h100_0000)));
      random_requests(60);
    end

    set_window(ferp_pkg::BASE_RESET, ferp_pkg::WINDOW_RESET);
    random_requests(22);

    drain();
    board.close();
    if (board.errors == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule
